/* design/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the bounding box design.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Same-cycle implication, disabled while reset is high
`define ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle implication failed");

// Next-cycle implication, disabled while reset is high
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle implication failed");

`else

`define ASSERT_IMPLY(lbl, clk, rst, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst, ante, cons)

`endif

`endif

/* design/bbt_pkg.sv */
// ----------------------------------------------------------------------------
// bbt_pkg
// Types, register indexes and reset values for the backdrop trim bounding box.
// ----------------------------------------------------------------------------
package bbt_pkg;

   // Largest frame dimension handled by the counters
   localparam int DEFAULT_MAX_DIMENSION = 4096;

   // Field widths
   localparam int CHAN_W   = 8;
   localparam int SIZE_W   = 13;
   localparam int POS_W    = 12;
   localparam int CSR_IDX_W = 2;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_WIDTH      = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_HEIGHT     = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_BRIGHT_THRESHOLD = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SPREAD_LIMIT     = 2'd3;

   // Register reset values
   localparam logic [SIZE_W-1:0] RST_FRAME_WIDTH      = 13'd256;
   localparam logic [SIZE_W-1:0] RST_FRAME_HEIGHT     = 13'd256;
   localparam logic [CHAN_W-1:0] RST_BRIGHT_THRESHOLD = 8'd235;
   localparam logic [CHAN_W-1:0] RST_SPREAD_LIMIT     = 8'd12;

   // Configuration as seen by the datapath
   typedef struct packed {
      logic [SIZE_W-1:0] frame_width;
      logic [SIZE_W-1:0] frame_height;
      logic [CHAN_W-1:0] bright_threshold;
      logic [CHAN_W-1:0] spread_limit;
   } bbt_cfg_type;

   // One pixel
   typedef struct packed {
      logic [CHAN_W-1:0] blue;
      logic [CHAN_W-1:0] green;
      logic [CHAN_W-1:0] red;
   } bbt_pixel_type;

   // One crop rectangle
   typedef struct packed {
      logic              found;
      logic [POS_W-1:0]  left;
      logic [POS_W-1:0]  top;
      logic [SIZE_W-1:0] crop_width;
      logic [SIZE_W-1:0] crop_height;
   } bbt_result_type;

endpackage

/* design/backdrop_trim_bounding_box.sv */
// ----------------------------------------------------------------------------
// backdrop_trim_bounding_box
// Crop rectangle of the foreground in a raster RGB frame with a light,
// even-toned backdrop trimmed away.
// ----------------------------------------------------------------------------
//
//   channel  direction  contents
//   req_     in         one pixel: red, green, blue
//   rsp_     out        one crop rectangle per frame, after its last pixel
//   csr_     in         frame size, brightness threshold, spread limit
//
// One pixel a cycle unless the result stalls: a pixel register feeds the
// classifier and tracker, and a result register holds the rectangle, formed
// from the last pixel once it leaves the pixel register. Synchronous reset
// restores register defaults and starts a fresh frame. A stalled result
// stalls the pixel register, and then req_tready.
//
`include "assert_macros.svh"

module backdrop_trim_bounding_box import bbt_pkg::*; #(
   parameter int MAX_DIMENSION = DEFAULT_MAX_DIMENSION
) (
   input  logic                 clock,
   input  logic                 reset,
   // pixel stream
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [23:0]          req_tdata,  // red[7:0], green[15:8], blue[23:16]
   // rectangle stream
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [55:0]          rsp_tdata,  // left[11:0], top[23:12],
                                            // crop_width[36:24], crop_height[49:37]
   output logic                 rsp_tuser,  // found[0]
   // register writes
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [SIZE_W-1:0]    csr_wdata
);

   bbt_cfg_type    cfg_ff, cfg_in;
   bbt_pixel_type  pix_ff;
   logic           in_valid_ff;
   logic           rsp_valid_ff, rsp_valid_in;
   bbt_result_type rsp_ff;
   logic           advance;
   logic           backdrop;
   logic           result_valid;
   bbt_result_type result;

   // Write configuration registers
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_FRAME_WIDTH:      cfg_in.frame_width      = csr_wdata;
            CSR_FRAME_HEIGHT:     cfg_in.frame_height     = csr_wdata;
            CSR_BRIGHT_THRESHOLD: cfg_in.bright_threshold = csr_wdata[CHAN_W-1:0];
            CSR_SPREAD_LIMIT:     cfg_in.spread_limit     = csr_wdata[CHAN_W-1:0];
            default:              cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.frame_width      <= RST_FRAME_WIDTH;
         cfg_ff.frame_height     <= RST_FRAME_HEIGHT;
         cfg_ff.bright_threshold <= RST_BRIGHT_THRESHOLD;
         cfg_ff.spread_limit     <= RST_SPREAD_LIMIT;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Move the pixel on when the result slot is free next cycle
   assign advance    = !rsp_valid_ff || rsp_tready;
   assign req_tready = !in_valid_ff || advance;

   // Capture the pixel transaction
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         pix_ff <= bbt_pixel_type'(req_tdata);
      end
   end

   bbt_classify u_classify (
      .pixel    (pix_ff),
      .cfg      (cfg_ff),
      .backdrop (backdrop)
   );

   bbt_tracker #(
      .MAX_DIMENSION (MAX_DIMENSION)
   ) u_tracker (
      .clock        (clock),
      .reset        (reset),
      .step         (in_valid_ff && advance),
      .backdrop     (backdrop),
      .cfg          (cfg_ff),
      .result_valid (result_valid),
      .result       (result)
   );

   // Hold the rectangle until taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         rsp_valid_in = result_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && result_valid) begin
         rsp_ff <= result;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_ff.found;
   assign rsp_tdata  = {6'b0, rsp_ff.crop_height, rsp_ff.crop_width, rsp_ff.top, rsp_ff.left};

   // Checks on the pipeline and result forming
   `ASSERT_IMPLY(a_notfound_origin, clock, reset, rsp_valid_ff && !rsp_ff.found, rsp_ff.left == '0 && rsp_ff.top == '0)
   `ASSERT_NEXT(a_pixel_held, clock, reset, in_valid_ff && !advance, in_valid_ff)
   `ASSERT_IMPLY(a_rsp_source, clock, reset, $rose(rsp_valid_ff), $past(in_valid_ff))

endmodule

/* design/bbt_classify.sv */
// ----------------------------------------------------------------------------
// bbt_classify
// Flags a pixel as backdrop: bright enough and nearly gray.
// ----------------------------------------------------------------------------
module bbt_classify import bbt_pkg::*; (
   input  bbt_pixel_type pixel,
   input  bbt_cfg_type   cfg,
   output logic          backdrop
);

   logic [CHAN_W-1:0] lo;
   logic [CHAN_W-1:0] hi;
   logic [CHAN_W-1:0] lo_rg;
   logic [CHAN_W-1:0] hi_rg;

   // Find smallest and largest channel
   always_comb begin
      lo_rg = (pixel.green < pixel.red) ? pixel.green : pixel.red;
      hi_rg = (pixel.green > pixel.red) ? pixel.green : pixel.red;
      lo    = (pixel.blue < lo_rg) ? pixel.blue : lo_rg;
      hi    = (pixel.blue > hi_rg) ? pixel.blue : hi_rg;
   end

   // Backdrop when bright and with a small spread
   assign backdrop = (lo >= cfg.bright_threshold) && ((hi - lo) <= cfg.spread_limit);

endmodule

/* design/bbt_tracker.sv */
// ----------------------------------------------------------------------------
// bbt_tracker
// Raster counters and foreground extent tracking; forms the crop rectangle
// on the last pixel of each frame.
// ----------------------------------------------------------------------------
module bbt_tracker import bbt_pkg::*; #(
   parameter int MAX_DIMENSION = DEFAULT_MAX_DIMENSION
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           step,
   input  logic           backdrop,
   input  bbt_cfg_type    cfg,
   output logic           result_valid,
   output bbt_result_type result
);

   localparam int COORD_W = $clog2(MAX_DIMENSION);
   localparam int DIM_W   = COORD_W + 1;
   localparam int OUT_W   = (DIM_W > SIZE_W) ? DIM_W : SIZE_W;

   logic [COORD_W-1:0] col_ff, col_in;
   logic [COORD_W-1:0] row_ff, row_in;
   logic               seen_ff, seen_in;
   logic [COORD_W-1:0] lc_ff, lc_in;
   logic [COORD_W-1:0] gc_ff, gc_in;
   logic [COORD_W-1:0] lr_ff, lr_in;
   logic [COORD_W-1:0] gr_ff, gr_in;

   logic [DIM_W-1:0]   width_eff;
   logic [DIM_W-1:0]   height_eff;
   logic [DIM_W-1:0]   col_next;
   logic [DIM_W-1:0]   row_next;
   logic               row_end;
   logic               frame_end;
   logic               seen_upd;
   logic [COORD_W-1:0] lc_upd, gc_upd, lr_upd, gr_upd;
   logic [OUT_W-1:0]   span_col;
   logic [OUT_W-1:0]   span_row;
   logic [OUT_W-1:0]   lc_ext, lr_ext, w_ext, h_ext;

   // Clamp frame size into 1..MAX_DIMENSION
   always_comb begin
      if (cfg.frame_width == '0) begin
         width_eff = DIM_W'(1);
      end else if (32'(cfg.frame_width) > MAX_DIMENSION) begin
         width_eff = DIM_W'(MAX_DIMENSION);
      end else begin
         width_eff = DIM_W'(cfg.frame_width);
      end
      if (cfg.frame_height == '0) begin
         height_eff = DIM_W'(1);
      end else if (32'(cfg.frame_height) > MAX_DIMENSION) begin
         height_eff = DIM_W'(MAX_DIMENSION);
      end else begin
         height_eff = DIM_W'(cfg.frame_height);
      end
   end

   // Detect end of row and end of frame
   assign col_next  = DIM_W'(col_ff) + DIM_W'(1);
   assign row_next  = DIM_W'(row_ff) + DIM_W'(1);
   assign row_end   = (col_next >= width_eff);
   assign frame_end = row_end && (row_next >= height_eff);

   // Widen extents for the foreground pixel
   always_comb begin
      seen_upd = seen_ff;
      lc_upd   = lc_ff;
      gc_upd   = gc_ff;
      lr_upd   = lr_ff;
      gr_upd   = gr_ff;
      if (!backdrop) begin
         seen_upd = 1'b1;
         if (!seen_ff) begin
            lc_upd = col_ff;
            gc_upd = col_ff;
            lr_upd = row_ff;
            gr_upd = row_ff;
         end else begin
            if (col_ff < lc_ff) lc_upd = col_ff;
            if (col_ff > gc_ff) gc_upd = col_ff;
            if (row_ff < lr_ff) lr_upd = row_ff;
            if (row_ff > gr_ff) gr_upd = row_ff;
         end
      end
   end

   // Advance counters; clear tracking at frame end
   always_comb begin
      col_in  = col_ff;
      row_in  = row_ff;
      seen_in = seen_ff;
      lc_in   = lc_ff;
      gc_in   = gc_ff;
      lr_in   = lr_ff;
      gr_in   = gr_ff;
      if (step) begin
         col_in  = row_end ? '0 : col_next[COORD_W-1:0];
         seen_in = seen_upd;
         lc_in   = lc_upd;
         gc_in   = gc_upd;
         lr_in   = lr_upd;
         gr_in   = gr_upd;
         if (frame_end) begin
            row_in  = '0;
            seen_in = 1'b0;
            lc_in   = '0;
            gc_in   = '0;
            lr_in   = '0;
            gr_in   = '0;
         end else if (row_end) begin
            row_in = row_next[COORD_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff  <= '0;
         row_ff  <= '0;
         seen_ff <= 1'b0;
         lc_ff   <= '0;
         gc_ff   <= '0;
         lr_ff   <= '0;
         gr_ff   <= '0;
      end else begin
         col_ff  <= col_in;
         row_ff  <= row_in;
         seen_ff <= seen_in;
         lc_ff   <= lc_in;
         gc_ff   <= gc_in;
         lr_ff   <= lr_in;
         gr_ff   <= gr_in;
      end
   end

   // Form the crop rectangle
   assign lc_ext   = OUT_W'(lc_upd);
   assign lr_ext   = OUT_W'(lr_upd);
   assign w_ext    = OUT_W'(width_eff);
   assign h_ext    = OUT_W'(height_eff);
   assign span_col = OUT_W'(gc_upd) - lc_ext + OUT_W'(1);
   assign span_row = OUT_W'(gr_upd) - lr_ext + OUT_W'(1);

   assign result_valid = step && frame_end;

   always_comb begin
      if (seen_upd) begin
         result.found       = 1'b1;
         result.left        = lc_ext[POS_W-1:0];
         result.top         = lr_ext[POS_W-1:0];
         result.crop_width  = span_col[SIZE_W-1:0];
         result.crop_height = span_row[SIZE_W-1:0];
      end else begin
         result.found       = 1'b0;
         result.left        = '0;
         result.top         = '0;
         result.crop_width  = w_ext[SIZE_W-1:0];
         result.crop_height = h_ext[SIZE_W-1:0];
      end
   end

endmodule

/* bench/backdrop_trim_bounding_box_tb.sv */
// ----------------------------------------------------------------------------
// backdrop_trim_bounding_box_tb
// Streams RGB frames into the bounding box block and checks every crop
// rectangle it returns against a cycle-free model of the backdrop classifier
// and the foreground tracker. A short table of directed steps covers the
// register reset values, the classification edges and the smallest frame
// size. Random phases with changing configuration, random idling on both
// sides and one long output hold-off follow.
// ----------------------------------------------------------------------------
module backdrop_trim_bounding_box_tb;
   import bbt_pkg::*;

   localparam int DRAIN_CYCLES  = 8;     // settle time once the last rectangle is in
   localparam int HOLD_CYCLES   = 200;   // long output hold-off
   localparam int RANDOM_ITEMS  = 1350;
   localparam int MIN_FRAMES    = 60;
   localparam int QUIET_ITEMS   = 300;   // closing stretch without idling
   localparam int LIMIT_TIME    = 100_000_000;

   typedef enum logic {ROW_PIXELS, ROW_WRITE} row_kind_type;

   // One line of the directed table: a register write or a run of equal pixels
   typedef struct packed {
      row_kind_type          kind;
      logic [CSR_IDX_W-1:0]  idx;
      logic [SIZE_W-1:0]     value;
      bbt_pixel_type         px;
      logic [SIZE_W-1:0]     count;
      logic                  typed;
      bbt_result_type        want;
   } step_row_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [23:0]           req_tdata = '0;   // red[7:0], green[15:8], blue[23:16]
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b1;
   logic [55:0]           rsp_tdata;        // left[11:0], top[23:12],
                                            // crop_width[36:24], crop_height[49:37]
   logic                  rsp_tuser;        // found[0]
   logic                  csr_we = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = CSR_FRAME_WIDTH;
   logic [SIZE_W-1:0]     csr_wdata = '0;

   // Configuration mirror
   logic [SIZE_W-1:0]     cfg_width  = RST_FRAME_WIDTH;
   logic [SIZE_W-1:0]     cfg_height = RST_FRAME_HEIGHT;
   logic [CHAN_W-1:0]     cfg_thresh = RST_BRIGHT_THRESHOLD;
   logic [CHAN_W-1:0]     cfg_spread = RST_SPREAD_LIMIT;

   // Raster position and foreground extent of the frame in progress
   int                    col_pos, row_pos;
   bit                    fg_seen;
   int                    min_col, max_col, min_row, max_row;

   bbt_result_type        pending_crops[$];
   step_row_type          directed_steps[$];
   bbt_result_type        got_rect, want_rect;
   int                    errors;
   int                    crops_predicted;
   int                    gap_chance;
   int                    stall_chance;
   bit                    hold_output;

   backdrop_trim_bounding_box DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Frame size as the counters see it
   function automatic int effective_size(input logic [SIZE_W-1:0] v);
      if (v == 0) return 1;
      if (v > DEFAULT_MAX_DIMENSION) return DEFAULT_MAX_DIMENSION;
      return int'(v);
   endfunction

   // Classify one pixel, track it and advance the raster; 1 when a frame closes
   function automatic bit predict_crop(input bbt_pixel_type px, output bbt_result_type rect);
      int lo, hi, w, h;
      lo = px.red;
      hi = px.red;
      if (px.green < lo) lo = px.green;
      if (px.blue < lo) lo = px.blue;
      if (px.green > hi) hi = px.green;
      if (px.blue > hi) hi = px.blue;
      w = effective_size(cfg_width);
      h = effective_size(cfg_height);
      rect = '0;
      if (!(lo >= int'(cfg_thresh) && hi - lo <= int'(cfg_spread))) begin
         if (!fg_seen) begin
            min_col = col_pos;
            max_col = col_pos;
            min_row = row_pos;
            max_row = row_pos;
            fg_seen = 1'b1;
         end else begin
            if (col_pos < min_col) min_col = col_pos;
            if (col_pos > max_col) max_col = col_pos;
            if (row_pos < min_row) min_row = row_pos;
            if (row_pos > max_row) max_row = row_pos;
         end
      end
      if (col_pos + 1 < w) begin
         col_pos++;
         return 1'b0;
      end
      col_pos = 0;
      if (row_pos + 1 < h) begin
         row_pos++;
         return 1'b0;
      end
      // Frame closes: report the extent, or the full frame when nothing was seen
      if (fg_seen) begin
         rect.found       = 1'b1;
         rect.left        = POS_W'(min_col);
         rect.top         = POS_W'(min_row);
         rect.crop_width  = SIZE_W'(max_col - min_col + 1);
         rect.crop_height = SIZE_W'(max_row - min_row + 1);
      end else begin
         rect.crop_width  = SIZE_W'(w);
         rect.crop_height = SIZE_W'(h);
      end
      row_pos = 0;
      fg_seen = 1'b0;
      min_col = 0;
      max_col = 0;
      min_row = 0;
      max_row = 0;
      return 1'b1;
   endfunction

   // Mostly near-backdrop pixels around the current limits, the rest anything
   function automatic bbt_pixel_type make_pixel();
      bbt_pixel_type px;
      int lo, hi;
      if ($urandom_range(0, 9) < 7) begin
         lo = $urandom_range(int'(cfg_thresh), 255);
         if (lo > 0 && $urandom_range(0, 5) == 0) lo--;
         hi = lo + $urandom_range(0, int'(cfg_spread) + 2);
         if (hi > 255) hi = 255;
         px.red   = CHAN_W'($urandom_range(lo, hi));
         px.green = CHAN_W'($urandom_range(lo, hi));
         px.blue  = CHAN_W'($urandom_range(lo, hi));
      end else begin
         px = bbt_pixel_type'($urandom);
      end
      return px;
   endfunction

   // Mostly small sizes, sometimes zero, the maximum or anything the port takes
   function automatic logic [SIZE_W-1:0] pick_size(input int top_small);
      case ($urandom_range(0, 15))
         0:       return '0;
         1:       return SIZE_W'($urandom_range(0, 8191));
         2:       return SIZE_W'(DEFAULT_MAX_DIMENSION);
         default: return SIZE_W'($urandom_range(1, top_small));
      endcase
   endfunction

   function automatic bbt_result_type rect_of(input logic f, input int l, input int t,
                                              input int w, input int h);
      bbt_result_type r;
      r.found       = f;
      r.left        = POS_W'(l);
      r.top         = POS_W'(t);
      r.crop_width  = SIZE_W'(w);
      r.crop_height = SIZE_W'(h);
      return r;
   endfunction

   task automatic add_write(input logic [CSR_IDX_W-1:0] idx, input int value);
      step_row_type r;
      r = '0;
      r.kind  = ROW_WRITE;
      r.idx   = idx;
      r.value = SIZE_W'(value);
      directed_steps.push_back(r);
   endtask

   // A run of equal pixels; with typed set, its last pixel closes a frame with want
   task automatic add_pixels(input int red, input int green, input int blue, input int n,
                             input logic typed, input bbt_result_type want);
      step_row_type r;
      r = '0;
      r.kind     = ROW_PIXELS;
      r.px.red   = CHAN_W'(red);
      r.px.green = CHAN_W'(green);
      r.px.blue  = CHAN_W'(blue);
      r.count    = SIZE_W'(n);
      r.typed    = typed;
      r.want     = want;
      directed_steps.push_back(r);
   endtask

   // Offer one pixel, hold it until the transaction completes, then predict
   task automatic send_pixel(input bbt_pixel_type px, input bit typed,
                             input bbt_result_type want);
      bbt_result_type rect;
      bit closes;
      if (gap_chance != 0 && $urandom_range(1, 8) <= gap_chance) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 16)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= px;
      do @(posedge clock); while (!req_tready);
      closes = predict_crop(px, rect);
      if (typed) pending_crops.push_back(want);
      else if (closes) pending_crops.push_back(rect);
      if (closes) crops_predicted++;
   endtask

   // Drop valid, let every rectangle arrive and the pipeline empty out
   task automatic wait_idle();
      req_tvalid <= 1'b0;
      while (pending_crops.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [SIZE_W-1:0] value);
      wait_idle();
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      case (idx)
         CSR_FRAME_WIDTH:      cfg_width  = value;
         CSR_FRAME_HEIGHT:     cfg_height = value;
         CSR_BRIGHT_THRESHOLD: cfg_thresh = value[CHAN_W-1:0];
         CSR_SPREAD_LIMIT:     cfg_spread = value[CHAN_W-1:0];
         default: ;
      endcase
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   task automatic check_field(input string name, input logic [SIZE_W-1:0] want,
                              input logic [SIZE_W-1:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch: expected %0d, got %0d", $time, name, want, got);
         errors++;
      end
   endtask

   // Compare each rectangle transaction with the oldest prediction
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         got_rect.found       = rsp_tuser;
         got_rect.left        = rsp_tdata[11:0];
         got_rect.top         = rsp_tdata[23:12];
         got_rect.crop_width  = rsp_tdata[36:24];
         got_rect.crop_height = rsp_tdata[49:37];
         if (pending_crops.size() == 0) begin
            $display("%0t: unexpected rectangle: expected none, got %h", $time, got_rect);
            errors++;
         end else begin
            want_rect = pending_crops.pop_front();
            check_field("found", SIZE_W'(want_rect.found), SIZE_W'(got_rect.found));
            check_field("left", SIZE_W'(want_rect.left), SIZE_W'(got_rect.left));
            check_field("top", SIZE_W'(want_rect.top), SIZE_W'(got_rect.top));
            check_field("crop_width", want_rect.crop_width, got_rect.crop_width);
            check_field("crop_height", want_rect.crop_height, got_rect.crop_height);
         end
      end
   end

   // Output side: random stall bursts, or one long hold-off on request
   initial begin
      forever begin
         @(posedge clock);
         if (hold_output) begin
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            rsp_tready <= 1'b1;
            hold_output = 1'b0;
         end else if (stall_chance != 0 && $urandom_range(1, 8) <= stall_chance) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge clock);
            rsp_tready <= 1'b1;
         end
      end
   end

   initial begin
      #(LIMIT_TIME);
      $display("backdrop_trim_bounding_box_tb: FAIL");
      $finish;
   end

   initial begin
      step_row_type row;
      int rand_items, frames_base, len;
      gap_chance   = 2;
      stall_chance = 2;

      // Reset width, threshold and spread stay; a single-row frame shows them
      add_write(CSR_FRAME_HEIGHT, 1);
      add_pixels(255, 255, 255, 256, 1'b1, rect_of(1'b0, 0, 0, 256, 1));
      add_pixels(235, 235, 235, 10, 1'b0, '0);   // darkest backdrop
      add_pixels(234, 240, 240, 1, 1'b0, '0);    // one below the threshold
      add_pixels(235, 247, 240, 1, 1'b0, '0);    // spread right at the limit
      add_pixels(235, 248, 240, 1, 1'b0, '0);    // spread one past the limit
      add_pixels(255, 255, 255, 243, 1'b1, rect_of(1'b1, 10, 0, 3, 1));
      // Zero sizes act as one; the loosest limits make everything backdrop
      add_write(CSR_FRAME_WIDTH, 0);
      add_write(CSR_FRAME_HEIGHT, 0);
      add_write(CSR_BRIGHT_THRESHOLD, 0);
      add_write(CSR_SPREAD_LIMIT, 255);
      add_pixels(0, 255, 0, 1, 1'b1, rect_of(1'b0, 0, 0, 1, 1));
      // Strictest limits: only pure white is backdrop
      add_write(CSR_BRIGHT_THRESHOLD, 255);
      add_write(CSR_SPREAD_LIMIT, 0);
      add_pixels(255, 255, 255, 1, 1'b1, rect_of(1'b0, 0, 0, 1, 1));
      add_pixels(255, 255, 254, 1, 1'b1, rect_of(1'b1, 0, 0, 1, 1));
      // Narrow the row while the column counter is past the new end
      add_write(CSR_FRAME_WIDTH, 4);
      add_write(CSR_FRAME_HEIGHT, 4);
      add_write(CSR_BRIGHT_THRESHOLD, 235);
      add_write(CSR_SPREAD_LIMIT, 12);
      add_pixels(255, 255, 255, 6, 1'b0, '0);
      add_write(CSR_FRAME_WIDTH, 2);
      add_pixels(0, 0, 0, 1, 1'b0, '0);
      add_pixels(255, 255, 255, 4, 1'b0, '0);

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Walk the directed table
      foreach (directed_steps[i]) begin
         row = directed_steps[i];
         if (row.kind == ROW_WRITE) begin
            write_reg(row.idx, row.value);
         end else begin
            for (int k = 0; k < row.count; k++)
               send_pixel(row.px, row.typed && k == row.count - 1, row.want);
         end
      end

      // One-pixel frames behind a long output hold-off fill the block up
      gap_chance = 0;
      write_reg(CSR_FRAME_WIDTH, 1);
      write_reg(CSR_FRAME_HEIGHT, 1);
      hold_output = 1'b1;
      repeat (40) send_pixel(make_pixel(), 1'b0, '0);

      // Random phases, each with its own configuration and idling mix
      rand_items  = 0;
      frames_base = crops_predicted;
      while (rand_items < RANDOM_ITEMS || crops_predicted - frames_base < MIN_FRAMES) begin
         write_reg(CSR_FRAME_WIDTH, pick_size(8));
         write_reg(CSR_FRAME_HEIGHT, pick_size(6));
         case ($urandom_range(0, 7))
            0:       write_reg(CSR_BRIGHT_THRESHOLD, 0);
            1:       write_reg(CSR_BRIGHT_THRESHOLD, 255);
            default: write_reg(CSR_BRIGHT_THRESHOLD, SIZE_W'($urandom_range(0, 255)));
         endcase
         case ($urandom_range(0, 7))
            0:       write_reg(CSR_SPREAD_LIMIT, 0);
            1:       write_reg(CSR_SPREAD_LIMIT, 255);
            default: write_reg(CSR_SPREAD_LIMIT, SIZE_W'($urandom_range(0, 40)));
         endcase
         if (rand_items >= RANDOM_ITEMS - QUIET_ITEMS) begin
            gap_chance   = 0;
            stall_chance = 0;
         end else begin
            gap_chance   = $urandom_range(0, 3);
            stall_chance = $urandom_range(0, 3);
         end
         len = $urandom_range(10, 80);
         repeat (len) begin
            send_pixel(make_pixel(), 1'b0, '0);
            rand_items++;
         end
      end

      wait_idle();
      if (errors == 0)
         $display("backdrop_trim_bounding_box_tb: PASS");
      else
         $display("backdrop_trim_bounding_box_tb: FAIL");
      $finish;
   end

endmodule

/* sim.f */
+incdir+design
design/bbt_pkg.sv
design/bbt_classify.sv
design/bbt_tracker.sv
design/backdrop_trim_bounding_box.sv
bench/backdrop_trim_bounding_box_tb.sv
